// ===== rtl/bitmap_slot_allocator_macros.svh =====
// Assertion macros shared by the slot allocator modules.
// Depends on nothing; the asserting modules expect signals clk and arst_n in scope.
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is active.
`define BSA_ASSERT_IMM(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Next-cycle implication, disabled while reset is active.
`define BSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define BSA_ASSERT_IMM(lbl, ante, cons)
`define BSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the bitmap slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsa_pkg;

	// Field widths fixed by the request and result formats.
	localparam int TYPE_W  = 3;
	localparam int POS_W   = 12;
	localparam int COUNT_W = 13;

	// Default geometry and the slot count after reset.
	localparam int MAX_SLOTS_DEF  = 4096;
	localparam int WORD_BITS_DEF  = 32;
	localparam int SLOT_COUNT_RST = 4096;

	// Request codes.
	localparam logic [TYPE_W-1:0] REQ_TAKE    = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_RELEASE = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY   = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_FIND    = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_CLEAR   = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] slot;
	} rsp_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic sweep_start;
		logic sweep_step;
		logic load_rsp;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_is_clear;
		logic sweep_last;
		logic rsp_busy;
	} sts_t;

endpackage

// ===== rtl/bsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/bsa_ctrl.sv =====
// Controller state machine of the slot allocator.
// Depends on bsa_pkg and the assertion macros.
`include "bitmap_slot_allocator_macros.svh"
module bsa_ctrl import bsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = sts.req_is_clear ? ST_CLEAR : ST_EXEC;
			end
			ST_CLEAR: begin
				if (sts.sweep_last) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!sts.rsp_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Output logic.
	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.accept = req_valid;
				cmd.sweep_start = req_valid && sts.req_is_clear;
			end
			ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
			end
			ST_EXEC: begin
				cmd.load_rsp = !sts.rsp_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A request other than clear all goes straight to execution.
	`BSA_ASSERT_NXT(a_accept_exec, cmd.accept && !sts.req_is_clear, state_q == ST_EXEC)
	// Loading a result always returns the controller to idle.
	`BSA_ASSERT_NXT(a_load_idle, cmd.load_rsp, state_q == ST_IDLE)
	// The last sweep step of a clear hands over to execution.
	`BSA_ASSERT_NXT(a_clear_done, state_q == ST_CLEAR && sts.sweep_last, state_q == ST_EXEC)

endmodule

// ===== rtl/bsa_datapath.sv =====
// Datapath of the slot allocator: free map RAM, word summary, sweep counter,
// slot count register and result register. Depends on bsa_pkg, bsa_ram and the macros.
`include "bitmap_slot_allocator_macros.svh"
module bsa_datapath import bsa_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  req_t               req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp_data,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data
);

	// WORD_BITS is a power of two, so word and bit indexes are slices of a position.
	localparam int DEPTH = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int XW = (($clog2(MAX_SLOTS + 1) > COUNT_W) ? $clog2(MAX_SLOTS + 1) : COUNT_W) + 1;
	localparam int RST_CNT = (MAX_SLOTS < SLOT_COUNT_RST) ? MAX_SLOTS : SLOT_COUNT_RST;

	logic [COUNT_W-1:0]   slot_count_q;
	req_t                 req_q;
	logic                 pos_ok_q;
	logic [AW-1:0]        ff_word_q;
	logic                 ff_any_q;
	logic [AW-1:0]        sweep_idx_q;
	logic [XW-1:0]        sweep_cnt_q;
	logic [DEPTH-1:0]     summary_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [XW-1:0]        eff_cnt;
	logic [XW-1:0]        word_lim;
	logic [DEPTH-1:0]     allowed;
	logic [DEPTH-1:0]     cand;
	logic [DEPTH-1:0]     cand_iso;
	logic [AW-1:0]        cand_idx;
	logic                 in_ok;
	logic [AW-1:0]        in_word;
	logic [AW-1:0]        q_word;
	logic [BW-1:0]        q_bit;
	logic [WORD_BITS-1:0] q_mask;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] word_m;
	logic [WORD_BITS-1:0] word_iso;
	logic [BW-1:0]        bit_idx;
	logic                 ff_found;
	logic [POS_W-1:0]     ff_slot;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	rsp_t                 rsp_d;

	// Bits of word w whose slot lies below count cnt.
	function automatic logic [WORD_BITS-1:0] valid_mask(input logic [AW-1:0] w,
			input logic [XW-1:0] cnt);
		logic [XW-1:0] base;
		logic [XW-1:0] n;
		base = XW'(w) << BW;
		n = cnt - base;
		if (base >= cnt) return '0;
		if (n >= XW'(WORD_BITS)) return '1;
		return ~({WORD_BITS{1'b1}} << n[BW-1:0]);
	endfunction

	// Effective slot count saturates at the map size.
	assign eff_cnt = (XW'(slot_count_q) > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS) : XW'(slot_count_q);

	// Position checks for the incoming request and the held one.
	assign in_ok   = XW'(req_data.position) < eff_cnt;
	assign in_word = AW'(XW'(req_data.position) >> BW);
	assign q_word  = AW'(XW'(req_q.position) >> BW);
	assign q_bit   = req_q.position[BW-1:0];
	assign q_mask  = WORD_BITS'(1) << q_bit;

	// Lowest non-empty word among the words that hold valid slots.
	assign word_lim = (eff_cnt + XW'(WORD_BITS - 1)) >> BW;
	always_comb begin
		for (int w = 0; w < DEPTH; w++) begin
			allowed[w] = XW'(w) < word_lim;
		end
	end
	assign cand     = summary_q & allowed;
	assign cand_iso = cand & (~cand + DEPTH'(1));
	always_comb begin
		cand_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cand_iso[i]) cand_idx = cand_idx | AW'(i);
		end
	end

	// Lowest free bit of the word read for find first.
	assign word_m   = rd_data & valid_mask(ff_word_q, eff_cnt);
	assign word_iso = word_m & (~word_m + WORD_BITS'(1));
	always_comb begin
		bit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (word_iso[i]) bit_idx = bit_idx | BW'(i);
		end
	end
	assign ff_found = ff_any_q && (|word_m);
	assign ff_slot  = ff_found ? POS_W'((XW'(ff_word_q) << BW) | XW'(bit_idx)) : '0;

	// Map read: issued when a request is accepted.
	assign rd_en   = cmd.accept;
	assign rd_addr = (req_data.req_type == REQ_FIND) ? cand_idx : in_word;

	// Map write: sweep entries, or the modified word of a take or release.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = q_word;
		wr_data = rd_data;
		if (cmd.sweep_step) begin
			wr_en   = 1'b1;
			wr_addr = sweep_idx_q;
			wr_data = valid_mask(sweep_idx_q, sweep_cnt_q);
		end else if (cmd.load_rsp && pos_ok_q) begin
			if (req_q.req_type == REQ_TAKE) begin
				wr_en   = 1'b1;
				wr_data = rd_data & ~q_mask;
			end else if (req_q.req_type == REQ_RELEASE) begin
				wr_en   = 1'b1;
				wr_data = rd_data | q_mask;
			end
		end
	end

	bsa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result of the held request.
	always_comb begin
		rsp_d.found = 1'b0;
		rsp_d.slot  = req_q.position;
		unique case (req_q.req_type) inside
			REQ_TAKE, REQ_RELEASE: rsp_d.found = pos_ok_q;
			REQ_QUERY: rsp_d.found = pos_ok_q && ((rd_data & q_mask) != '0);
			REQ_FIND: begin
				rsp_d.found = ff_found;
				rsp_d.slot  = ff_slot;
			end
			REQ_CLEAR: rsp_d.found = 1'b1;
			default: rsp_d.found = 1'b0;
		endcase
	end

	// Control registers: slot count, sweep, summary and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= COUNT_W'(SLOT_COUNT_RST);
			sweep_idx_q  <= '0;
			sweep_cnt_q  <= XW'(RST_CNT);
			summary_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) slot_count_q <= cfg_wr_data;
			if (cmd.sweep_start) begin
				sweep_idx_q <= '0;
				sweep_cnt_q <= eff_cnt;
			end else if (cmd.sweep_step) begin
				sweep_idx_q <= sts.sweep_last ? '0 : sweep_idx_q + AW'(1);
			end
			if (wr_en) summary_q[wr_addr] <= |wr_data;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the held request and the result.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req_data;
			pos_ok_q <= in_ok;
			ff_word_q <= cand_idx;
			ff_any_q <= |cand;
		end
		if (cmd.load_rsp) rsp_q <= rsp_d;
	end

	// Status to the controller.
	assign sts.req_is_clear = req_data.req_type == REQ_CLEAR;
	assign sts.sweep_last   = sweep_idx_q == AW'(DEPTH - 1);
	assign sts.rsp_busy     = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// The summary bit follows every map write.
	`BSA_ASSERT_NXT(a_summary, wr_en, summary_q[$past(wr_addr)] == $past(|wr_data))
	// A loaded result is presented in the next cycle.
	`BSA_ASSERT_NXT(a_rsp_load, cmd.load_rsp, rsp_valid_q)
	// The map is never written by a request while a sweep runs.
	`BSA_ASSERT_IMM(a_no_overlap, cmd.sweep_step, !cmd.load_rsp && !cmd.accept)

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// Bitmap slot allocator with find-first-free over a summarized free map.
// Top level: joins bsa_ctrl and bsa_datapath; depends on bsa_pkg.
//
// Usage: requests enter on req_valid/req_stall with req_data (type and
// position); each request yields one result on rsp_valid/rsp_stall with
// rsp_data (found and slot). slot_count is written on cfg_wr_en/cfg_wr_data.
// Take, release, query and find first read the map word on acceptance
// (for find first, the word picked from the per-word summary), then
// evaluate, write back and load the result register in execution. No new
// request is taken until the current one leaves execution. Clear all
// rewrites every map word, one per cycle. After reset the same pass fills
// the map for a slot count of 4096, capped at MAX_SLOTS; req_stall stays
// high during it while configuration writes are still taken. A stalled
// result stays in the output register; the next request is still
// accepted and waits in execution until the register is free.
module bitmap_slot_allocator import bsa_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp_data,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Map storage and evaluation.
	bsa_datapath #(
		.MAX_SLOTS (MAX_SLOTS),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
